FILE: rtl/gmdfs_pkg.sv
// ----------------------------------------------------------------------------
// gmdfs_pkg
// shared types and constants of the grid maze depth-first path search
// ----------------------------------------------------------------------------
package gmdfs_pkg;

    // default grid edge length, handed to the top level parameter
    localparam int GRID_DIM_DEF = 8;

    // fixed field widths
    localparam int COORD_W    = 4;
    localparam int OP_W       = 2;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_MARK   = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS  = 3'd0,
        REG_NUM_COLS  = 3'd1,
        REG_START_ROW = 3'd2,
        REG_START_COL = 3'd3,
        REG_GOAL_ROW  = 3'd4,
        REG_GOAL_COL  = 3'd5
    } cfg_reg_t;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] NUM_ROWS_RST  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] NUM_COLS_RST  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] START_ROW_RST = 4'd1;
    localparam logic [CFG_DATA_W-1:0] START_COL_RST = 4'd1;
    localparam logic [CFG_DATA_W-1:0] GOAL_ROW_RST  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] GOAL_COL_RST  = 4'd8;

    // input beat
    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
    } cmd_t;

    // output beat
    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] path_row;
        logic [COORD_W-1:0] path_col;
        logic [STEP_W-1:0]  step_index;
        logic               last;
    } result_t;

endpackage

FILE: rtl/gmdfs_ram.sv
// ----------------------------------------------------------------------------
// gmdfs_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module gmdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/grid_maze_dfs_path_search.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_search
// obstacle grid with a stack-based depth-first path search from start to goal
// ----------------------------------------------------------------------------
// The block keeps a GRID_DIM x GRID_DIM obstacle map and answers three
// commands: mark one obstacle cell, clear the whole map, or search a path from
// the start cell to the goal cell set in the configuration registers.
// Mark and clear give no output beat. A search tries the
// neighbours of the cell on top of the stack in the order right, down, left,
// up, pushes the first free unvisited one and pops dead ends, which stay
// marked. It then streams the path from start to goal, one beat per cell with
// last on the goal, or a single beat with found low when no path exists.
// The search runs at the pace of the cell memory: it first reads and then
// marks the start cell, skips a neighbour outside the grid without a read,
// probes a neighbour with a memory read, then a check and optional push,
// and pops with a stack read of the new top; streaming reads each path beat
// from the stack once the output register is free. Input ready is high
// only while no search is running; a pending output beat does not hold
// off the next command.
module grid_maze_dfs_path_search
    import gmdfs_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cmd_t                         in_data,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output result_t                      out_data,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    // coordinate bits per axis, cell address bits, memory slots
    localparam int CW         = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int ADDR_W     = 2 * CW;
    localparam int CELL_SLOTS = 1 << ADDR_W;
    localparam int NUM_CELLS  = GRID_DIM * GRID_DIM;
    localparam int DEPTH_W    = $clog2(NUM_CELLS + 1);
    localparam logic [COORD_W-1:0] DIM_C = COORD_W'(GRID_DIM);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_START_RD = 10'b00_0000_0010,
        ST_START_WR = 10'b00_0000_0100,
        ST_PROBE    = 10'b00_0000_1000,
        ST_CHECK    = 10'b00_0001_0000,
        ST_POP      = 10'b00_0010_0000,
        ST_LOAD_TOP = 10'b00_0100_0000,
        ST_EMIT_RD  = 10'b00_1000_0000,
        ST_EMIT_LD  = 10'b01_0000_0000,
        ST_MISS     = 10'b10_0000_0000
    } state_t;

    // neighbour order of the search
    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_UP    = 2'd3
    } dir_t;

    // 1-based row/column to memory address
    function automatic logic [ADDR_W-1:0] coord_to_addr(
        input logic [COORD_W-1:0] row,
        input logic [COORD_W-1:0] col
    );
        logic [COORD_W-1:0] r0;
        logic [COORD_W-1:0] c0;
        r0 = row - COORD_W'(1);
        c0 = col - COORD_W'(1);
        return {r0[CW-1:0], c0[CW-1:0]};
    endfunction

    // configuration registers
    logic [CFG_DATA_W-1:0] num_rows_reg;
    logic [CFG_DATA_W-1:0] num_cols_reg;
    logic [CFG_DATA_W-1:0] start_row_reg;
    logic [CFG_DATA_W-1:0] start_col_reg;
    logic [CFG_DATA_W-1:0] goal_row_reg;
    logic [CFG_DATA_W-1:0] goal_col_reg;

    // control state
    state_t               state_reg,  state_next;
    dir_t                 dir_reg,    dir_next;
    logic [COORD_W-1:0]   top_row_reg, top_row_next;
    logic [COORD_W-1:0]   top_col_reg, top_col_next;
    logic [DEPTH_W-1:0]   depth_reg,  depth_next;
    logic [DEPTH_W-1:0]   k_reg,      k_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg,  out_data_next;

    // per-entry valid bits: an entry not valid reads as cleared
    logic [CELL_SLOTS-1:0] obs_vld_reg,  obs_vld_next;
    logic [CELL_SLOTS-1:0] mark_vld_reg, mark_vld_next;
    logic                  obs_vld_rd_reg,  obs_vld_rd_next;
    logic                  mark_vld_rd_reg, mark_vld_rd_next;

    // cell memory: bit 1 obstacle, bit 0 visit mark
    logic              cell_we;
    logic [ADDR_W-1:0] cell_waddr;
    logic [1:0]        cell_wdata;
    logic [ADDR_W-1:0] cell_raddr;
    logic [1:0]        cell_rdata;
    logic              cell_rd_en;

    // path stack memory: cell addresses, bottom is the start cell
    logic              stack_we;
    logic [ADDR_W-1:0] stack_waddr;
    logic [ADDR_W-1:0] stack_wdata;
    logic [ADDR_W-1:0] stack_raddr;
    logic [ADDR_W-1:0] stack_rdata;

    // derived values
    logic [COORD_W-1:0] rows_lim;
    logic [COORD_W-1:0] cols_lim;
    logic               start_ok;
    logic               start_is_goal;
    logic [ADDR_W-1:0]  start_addr;
    logic [COORD_W-1:0] nbr_row;
    logic [COORD_W-1:0] nbr_col;
    logic               nbr_ok;
    logic               nbr_is_goal;
    logic [ADDR_W-1:0]  nbr_addr;
    logic               cell_free;
    logic               out_free;
    logic               emit_last;

    gmdfs_ram #(
        .WIDTH (2),
        .DEPTH (CELL_SLOTS)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (cell_we),
        .wr_addr (cell_waddr),
        .wr_data (cell_wdata),
        .rd_addr (cell_raddr),
        .rd_data (cell_rdata)
    );

    gmdfs_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (CELL_SLOTS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (stack_we),
        .wr_addr (stack_waddr),
        .wr_data (stack_wdata),
        .rd_addr (stack_raddr),
        .rd_data (stack_rdata)
    );

    // oversized dimensions act as the full grid
    assign rows_lim = (num_rows_reg > DIM_C) ? DIM_C : num_rows_reg;
    assign cols_lim = (num_cols_reg > DIM_C) ? DIM_C : num_cols_reg;

    assign start_ok = (start_row_reg != '0) && (start_row_reg <= rows_lim)
                   && (start_col_reg != '0) && (start_col_reg <= cols_lim);
    assign start_is_goal = (start_row_reg == goal_row_reg)
                        && (start_col_reg == goal_col_reg);
    assign start_addr = coord_to_addr(start_row_reg, start_col_reg);

    // neighbour of the stack top in the current direction
    always_comb
    begin
        nbr_row = top_row_reg;
        nbr_col = top_col_reg;
        case (dir_reg)
            DIR_RIGHT: nbr_col = top_col_reg + COORD_W'(1);
            DIR_DOWN:  nbr_row = top_row_reg + COORD_W'(1);
            DIR_LEFT:  nbr_col = top_col_reg - COORD_W'(1);
            DIR_UP:    nbr_row = top_row_reg - COORD_W'(1);
            default:   nbr_row = top_row_reg;
        endcase
    end

    assign nbr_ok = (nbr_row != '0) && (nbr_row <= rows_lim)
                 && (nbr_col != '0) && (nbr_col <= cols_lim);
    assign nbr_is_goal = (nbr_row == goal_row_reg) && (nbr_col == goal_col_reg);
    assign nbr_addr = coord_to_addr(nbr_row, nbr_col);

    // probed cell is usable when neither a valid obstacle nor a valid mark
    assign cell_free = !(cell_rdata[1] && obs_vld_rd_reg)
                    && !(cell_rdata[0] && mark_vld_rd_reg);

    // output register frees up this edge or is already empty
    assign out_free  = !out_valid_reg || out_ready;
    assign emit_last = ((k_reg + DEPTH_W'(1)) == depth_reg);

    // reads issued only in these states; writes never share their cycle
    assign cell_rd_en = (state_reg == ST_START_RD) || ((state_reg == ST_PROBE) && nbr_ok);

    assign obs_vld_rd_next  = obs_vld_reg[cell_raddr];
    assign mark_vld_rd_next = mark_vld_reg[cell_raddr];

    always_comb
    begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        top_row_next   = top_row_reg;
        top_col_next   = top_col_reg;
        depth_next     = depth_reg;
        k_next         = k_reg;
        out_data_next  = out_data_reg;
        obs_vld_next   = obs_vld_reg;
        mark_vld_next  = mark_vld_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cell_we     = 1'b0;
        cell_waddr  = nbr_addr;
        cell_wdata  = 2'b01;
        cell_raddr  = nbr_addr;
        stack_we    = 1'b0;
        stack_waddr = ADDR_W'(depth_reg);
        stack_wdata = nbr_addr;
        stack_raddr = ADDR_W'(k_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.opcode)
                        OP_MARK:
                        begin
                            // cells beyond the rows/columns in use are stored
                            if ((in_data.cell_row != '0) && (in_data.cell_row <= DIM_C)
                                && (in_data.cell_col != '0) && (in_data.cell_col <= DIM_C))
                            begin
                                cell_we    = 1'b1;
                                cell_waddr = coord_to_addr(in_data.cell_row,
                                                           in_data.cell_col);
                                cell_wdata = 2'b10;
                                obs_vld_next[cell_waddr] = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            obs_vld_next = '0;
                        end
                        OP_SEARCH:
                        begin
                            mark_vld_next = '0;
                            depth_next    = '0;
                            state_next    = start_ok ? ST_START_RD : ST_MISS;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_START_RD:
            begin
                // fetch the start cell so its obstacle bit survives the mark
                cell_raddr = start_addr;
                state_next = ST_START_WR;
            end

            ST_START_WR:
            begin
                cell_we     = 1'b1;
                cell_waddr  = start_addr;
                cell_wdata  = {cell_rdata[1] && obs_vld_rd_reg, 1'b1};
                obs_vld_next[start_addr]  = 1'b1;
                mark_vld_next[start_addr] = 1'b1;
                stack_we     = 1'b1;
                stack_waddr  = '0;
                stack_wdata  = start_addr;
                depth_next   = DEPTH_W'(1);
                top_row_next = start_row_reg;
                top_col_next = start_col_reg;
                dir_next     = DIR_RIGHT;
                k_next       = '0;
                state_next   = start_is_goal ? ST_EMIT_RD : ST_PROBE;
            end

            ST_PROBE:
            begin
                if (nbr_ok)
                begin
                    cell_raddr = nbr_addr;
                    state_next = ST_CHECK;
                end
                else if (dir_reg == DIR_UP)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end

            ST_CHECK:
            begin
                if (cell_free)
                begin
                    // mark and push; the obstacle bit is known clear here
                    cell_we     = 1'b1;
                    cell_waddr  = nbr_addr;
                    cell_wdata  = 2'b01;
                    obs_vld_next[nbr_addr]  = 1'b1;
                    mark_vld_next[nbr_addr] = 1'b1;
                    stack_we     = 1'b1;
                    stack_waddr  = ADDR_W'(depth_reg);
                    stack_wdata  = nbr_addr;
                    depth_next   = depth_reg + DEPTH_W'(1);
                    top_row_next = nbr_row;
                    top_col_next = nbr_col;
                    dir_next     = DIR_RIGHT;
                    k_next       = '0;
                    state_next   = nbr_is_goal ? ST_EMIT_RD : ST_PROBE;
                end
                else if (dir_reg == DIR_UP)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = ST_PROBE;
                end
            end

            ST_POP:
            begin
                // dead end stays marked
                if (depth_reg == DEPTH_W'(1))
                begin
                    depth_next = '0;
                    state_next = ST_MISS;
                end
                else
                begin
                    depth_next  = depth_reg - DEPTH_W'(1);
                    stack_raddr = ADDR_W'(depth_reg - DEPTH_W'(2));
                    state_next  = ST_LOAD_TOP;
                end
            end

            ST_LOAD_TOP:
            begin
                top_row_next = COORD_W'(stack_rdata[ADDR_W-1:CW]) + COORD_W'(1);
                top_col_next = COORD_W'(stack_rdata[CW-1:0]) + COORD_W'(1);
                dir_next     = DIR_RIGHT;
                state_next   = ST_PROBE;
            end

            ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    stack_raddr = ADDR_W'(k_reg);
                    state_next  = ST_EMIT_LD;
                end
            end

            ST_EMIT_LD:
            begin
                out_valid_next           = 1'b1;
                out_data_next.found      = 1'b1;
                out_data_next.path_row   = COORD_W'(stack_rdata[ADDR_W-1:CW])
                                         + COORD_W'(1);
                out_data_next.path_col   = COORD_W'(stack_rdata[CW-1:0]) + COORD_W'(1);
                out_data_next.step_index = STEP_W'(k_reg) + STEP_W'(1);
                out_data_next.last       = emit_last;
                k_next                   = k_reg + DEPTH_W'(1);
                state_next               = emit_last ? ST_IDLE : ST_EMIT_RD;
            end

            ST_MISS:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.found      = 1'b0;
                    out_data_next.path_row   = '0;
                    out_data_next.path_col   = '0;
                    out_data_next.step_index = '0;
                    out_data_next.last       = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= NUM_ROWS_RST;
            num_cols_reg  <= NUM_COLS_RST;
            start_row_reg <= START_ROW_RST;
            start_col_reg <= START_COL_RST;
            goal_row_reg  <= GOAL_ROW_RST;
            goal_col_reg  <= GOAL_COL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_ROWS:  num_rows_reg  <= cfg_data;
                REG_NUM_COLS:  num_cols_reg  <= cfg_data;
                REG_START_ROW: start_row_reg <= cfg_data;
                REG_START_COL: start_col_reg <= cfg_data;
                REG_GOAL_ROW:  goal_row_reg  <= cfg_data;
                REG_GOAL_COL:  goal_col_reg  <= cfg_data;
                default:       num_rows_reg  <= num_rows_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dir_reg       <= DIR_RIGHT;
            depth_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            obs_vld_reg   <= '0;
            mark_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            depth_reg     <= depth_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            obs_vld_reg   <= obs_vld_next;
            mark_vld_reg  <= mark_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_row_reg     <= top_row_next;
        top_col_reg     <= top_col_next;
        out_data_reg    <= out_data_next;
        obs_vld_rd_reg  <= obs_vld_rd_next;
        mark_vld_rd_reg <= mark_vld_rd_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // no cell memory read collides with a write to the same entry
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cell_rd_en && cell_we && (cell_raddr == cell_waddr)))
        else $error("cell memory read and write hit the same entry");

    // the stack is never empty while neighbours are probed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE || state_reg == ST_CHECK) |-> (depth_reg != '0))
        else $error("probe with an empty stack");

    // a finished path ends with a step index equal to the stack depth
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && out_valid_reg
         && out_data_reg.found && out_data_reg.last)
        |-> (out_data_reg.step_index == STEP_W'(depth_reg)))
        else $error("final path beat does not match stack depth");

    // a not-found beat carries no coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.found)
        |-> (out_data_reg.last && (out_data_reg.step_index == '0)
             && (out_data_reg.path_row == '0) && (out_data_reg.path_col == '0)))
        else $error("malformed not-found beat");

endmodule

FILE: sim/tb_grid_maze_dfs_path_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_maze_dfs_path_search
// self-checking bench for the grid maze depth-first path search
// ----------------------------------------------------------------------------
// A table of directed commands and register writes covers the corner cases
// first: dropped off-grid obstacles, the unused opcode, a boxed-in start, an
// unreachable goal, start on goal, start on an obstacle, oversized and empty
// dimensions and long paths across the open grid. Six register settings
// with random maze builds and random noise follow. An accepted search with
// no typed result in the table is run through a local depth-first predictor,
// and each beat is checked field by field, in order, against the one owed.
// ----------------------------------------------------------------------------
module tb_grid_maze_dfs_path_search;
    import gmdfs_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int GRID          = GRID_DIM_DEF;
    localparam int CELLS         = GRID * GRID;
    localparam int NUM_REGS      = 6;
    localparam int IDLE_PCT      = 34;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 38;
    localparam int TIMEOUT_NS    = 40_000_000;
    localparam int DIR_ROWS      = 44;

    // opcode the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam cmd_t    SEARCH_CMD = '{OP_SEARCH, 4'd0, 4'd0};
    localparam cmd_t    CLEAR_CMD  = '{OP_CLEAR, 4'd0, 4'd0};
    // the lone beat of a search that finds nothing
    localparam result_t NO_PATH    = '{1'b0, 4'd0, 4'd0, 7'd0, 1'b1};
    // one-cell path when start sits on the goal at (1,1)
    localparam result_t AT_START   = '{1'b1, 4'd1, 4'd1, 7'd1, 1'b1};

    typedef enum int {DIR_RIGHT, DIR_DOWN, DIR_LEFT, DIR_UP} step_dir_t;
    typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

    // one line of the directed table: either a command or a register write
    typedef struct {
        row_kind_t             kind;
        cfg_reg_t              sel;
        logic [CFG_DATA_W-1:0] value;
        cmd_t                  cmd;
        bit                    typed;
        result_t               want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    cmd_t                  in_data;
    logic                  out_valid;
    logic                  out_ready;
    result_t               out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state: obstacle map and register shadow
    bit                    blocked [CELLS];
    logic [CFG_DATA_W-1:0] reg_copy [NUM_REGS];

    // beats still owed by the block, oldest first
    result_t pending_beats [$];

    // idling knobs shared with the receiver
    int in_idle_pct  = IDLE_PCT;
    int out_idle_pct = IDLE_PCT;
    bit hold_req     = 1'b0;

    int errors    = 0;
    int n_useful  = 0;
    int n_search  = 0;
    int n_found   = 0;
    int n_missing = 0;
    int n_beats   = 0;
    int n_writes  = 0;
    int longest   = 0;

    // directed commands; typed results only where they are plain to see
    plan_row_t dir_plan [DIR_ROWS] = '{
        // empty grid at reset: top row to the right, then down the last column
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH},
        // obstacles off the grid are dropped, the unused opcode does nothing
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd0, 4'd5},   1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd15, 4'd15}, 1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd4, 4'd0},   1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd9, 4'd9},   1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_UNUSED, 4'd8, 4'd8}, 1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH},
        // start boxed in by its right and lower neighbours
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd1, 4'd2},   1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd2, 4'd1},   1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b1, NO_PATH},
        // goal on an obstacle: the whole grid is explored for nothing
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  CLEAR_CMD,                1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd8, 4'd8},   1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b1, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  CLEAR_CMD,                1'b0, NO_PATH},
        // start equal to goal, then the same with an obstacle on the start
        '{ROW_CFG, REG_GOAL_ROW,  4'd1,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_GOAL_COL,  4'd1,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b1, AT_START},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd1, 4'd1},   1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b1, AT_START},
        // start on an obstacle still walks off it
        '{ROW_CFG, REG_GOAL_ROW,  4'd3,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_GOAL_COL,  4'd2,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH},
        // start below the grid
        '{ROW_CFG, REG_START_ROW, 4'd9,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b1, NO_PATH},
        // oversized dimensions act as the full grid
        '{ROW_CFG, REG_START_ROW, 4'd1,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_NUM_ROWS,  4'd15, SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_NUM_COLS,  4'd15, SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_GOAL_ROW,  4'd8,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_GOAL_COL,  4'd8,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH},
        // zero rows leaves no usable cell
        '{ROW_CFG, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b1, NO_PATH},
        // single row
        '{ROW_CFG, REG_NUM_ROWS,  4'd1,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_NUM_COLS,  4'd8,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_GOAL_ROW,  4'd1,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH},
        // obstacle beyond the rows in use is kept for later
        '{ROW_CFG, REG_NUM_ROWS,  4'd3,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  '{OP_MARK, 4'd6, 4'd6},   1'b0, NO_PATH},
        '{ROW_CFG, REG_NUM_ROWS,  4'd8,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_GOAL_ROW,  4'd8,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH},
        // goal in the middle of the open grid, long paths
        '{ROW_CFG, REG_GOAL_ROW,  4'd5,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CFG, REG_GOAL_COL,  4'd4,  SEARCH_CMD,               1'b0, NO_PATH},
        '{ROW_CMD, REG_NUM_ROWS,  4'd0,  SEARCH_CMD,               1'b0, NO_PATH}
    };

    grid_maze_dfs_path_search #(
        .GRID_DIM (GRID)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // prints one line per mismatch and counts it
    task automatic flag_error(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic bit on_grid(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
        return r >= 1 && r <= GRID && c >= 1 && c <= GRID;
    endfunction

    // depth-first walk over the shadow map, queues the beats it should stream
    function automatic void predict_search();
        int      rows, cols, sr, sc, gr, gc;
        int      depth, r, c, nr, nc, nidx, d, k;
        bit      seen [CELLS];
        int      stk [CELLS];
        bit      hit, moved;
        result_t beat;
        seen  = '{default: 1'b0};
        rows  = int'(reg_copy[REG_NUM_ROWS]);
        cols  = int'(reg_copy[REG_NUM_COLS]);
        rows  = (rows > GRID) ? GRID : rows;
        cols  = (cols > GRID) ? GRID : cols;
        sr    = int'(reg_copy[REG_START_ROW]);
        sc    = int'(reg_copy[REG_START_COL]);
        gr    = int'(reg_copy[REG_GOAL_ROW]);
        gc    = int'(reg_copy[REG_GOAL_COL]);
        depth = 0;
        hit   = 1'b0;
        // start outside the rows and columns in use never begins
        if (sr >= 1 && sr <= rows && sc >= 1 && sc <= cols) begin
            // the start cell itself is not checked against the obstacle map
            stk[0] = (sr - 1) * GRID + (sc - 1);
            seen[stk[0]] = 1'b1;
            depth = 1;
            hit = (sr == gr && sc == gc);
            while (!hit && depth > 0) begin
                r = stk[depth - 1] / GRID + 1;
                c = stk[depth - 1] % GRID + 1;
                moved = 1'b0;
                for (d = DIR_RIGHT; d <= DIR_UP && !moved; d++) begin
                    case (d)
                        DIR_RIGHT: begin nr = r;     nc = c + 1; end
                        DIR_DOWN:  begin nr = r + 1; nc = c;     end
                        DIR_LEFT:  begin nr = r;     nc = c - 1; end
                        default:   begin nr = r - 1; nc = c;     end
                    endcase
                    if (nr >= 1 && nr <= rows && nc >= 1 && nc <= cols) begin
                        nidx = (nr - 1) * GRID + (nc - 1);
                        if (!blocked[nidx] && !seen[nidx] && depth < CELLS) begin
                            seen[nidx] = 1'b1;
                            stk[depth] = nidx;
                            depth++;
                            moved = 1'b1;
                            hit = (nr == gr && nc == gc);
                        end
                    end
                end
                // dead ends keep their mark so they are never entered again
                if (!moved)
                    depth--;
            end
        end
        if (!hit)
            pending_beats.push_back(NO_PATH);
        else begin
            for (k = 0; k < depth; k++) begin
                beat.found      = 1'b1;
                beat.path_row   = COORD_W'(stk[k] / GRID + 1);
                beat.path_col   = COORD_W'(stk[k] % GRID + 1);
                beat.step_index = STEP_W'(k + 1);
                beat.last       = (k == depth - 1);
                pending_beats.push_back(beat);
            end
        end
    endfunction

    // effect of one accepted command on the shadow state
    function automatic void model_cmd(input cmd_t c);
        case (c.opcode)
            OP_MARK:
                if (on_grid(c.cell_row, c.cell_col))
                    blocked[(int'(c.cell_row) - 1) * GRID + int'(c.cell_col) - 1] = 1'b1;
            OP_CLEAR:
                blocked = '{default: 1'b0};
            OP_SEARCH:
                predict_search();
            default:
                ;
        endcase
    endfunction

    // offers one command beat, entered and left at a falling edge
    task automatic issue_cmd(input cmd_t c, input bit typed, input result_t want);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken at this edge
        if (c.opcode == OP_SEARCH || c.opcode == OP_CLEAR
                || (c.opcode == OP_MARK && on_grid(c.cell_row, c.cell_col)))
            n_useful++;
        if (c.opcode == OP_SEARCH)
            n_search++;
        if (typed)
            pending_beats.push_back(want);
        else
            model_cmd(c);
        @(negedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input cfg_reg_t sel, input int v);
        @(negedge clk);
        cfg_we        <= 1'b1;
        cfg_index     <= sel;
        cfg_data      <= CFG_DATA_W'(v);
        reg_copy[sel] = CFG_DATA_W'(v);
        n_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // lower valid, wait for every owed beat, then give mark and clear time to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // register values for one random phase, extremes first
    task automatic set_phase(input int p);
        int v [NUM_REGS];
        int i;
        case (p)
            0: v = '{8, 8, 1, 1, 8, 8};
            1: v = '{1, 1, 1, 1, 1, 1};
            2: v = '{15, 15, 8, 8, 1, 1};
            3: v = '{8, 8, $urandom_range(1, 8), $urandom_range(1, 8),
                     $urandom_range(1, 8), $urandom_range(1, 8)};
            4: begin
                v[REG_NUM_ROWS]  = $urandom_range(2, 8);
                v[REG_NUM_COLS]  = $urandom_range(2, 8);
                v[REG_START_ROW] = $urandom_range(1, v[REG_NUM_ROWS]);
                v[REG_START_COL] = $urandom_range(1, v[REG_NUM_COLS]);
                v[REG_GOAL_ROW]  = $urandom_range(1, v[REG_NUM_ROWS]);
                v[REG_GOAL_COL]  = $urandom_range(1, v[REG_NUM_COLS]);
            end
            default: v = '{$urandom_range(0, 15), $urandom_range(0, 15),
                           $urandom_range(0, 9), $urandom_range(0, 9),
                           $urandom_range(0, 9), $urandom_range(0, 9)};
        endcase
        for (i = 0; i < NUM_REGS; i++)
            write_reg(cfg_reg_t'(i), v[i]);
    endtask

    // mostly maze builds ending in a search, some raw noise on every field
    task automatic random_phase();
        int   rows, cols, base;
        cmd_t c;
        rows = int'(reg_copy[REG_NUM_ROWS]);
        cols = int'(reg_copy[REG_NUM_COLS]);
        rows = (rows == 0 || rows > GRID) ? GRID : rows;
        cols = (cols == 0 || cols > GRID) ? GRID : cols;
        base = n_useful;
        while (n_useful - base < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 75) begin
                if ($urandom_range(0, 2) == 0)
                    issue_cmd(CLEAR_CMD, 1'b0, NO_PATH);
                repeat ($urandom_range(0, 10))
                    issue_cmd(cmd_t'{OP_MARK, COORD_W'($urandom_range(1, rows)),
                                     COORD_W'($urandom_range(1, cols))}, 1'b0, NO_PATH);
                issue_cmd(cmd_t'{OP_SEARCH, COORD_W'($urandom_range(0, 15)),
                                 COORD_W'($urandom_range(0, 15))}, 1'b0, NO_PATH);
            end else begin
                c.opcode   = OP_W'($urandom_range(0, 3));
                c.cell_row = COORD_W'($urandom_range(0, 15));
                c.cell_col = COORD_W'($urandom_range(0, 15));
                issue_cmd(c, 1'b0, NO_PATH);
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial begin : result_sink
        int held;
        out_ready = 1'b0;
        held = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_req = 1'b0;
                    held = 0;
                end
            end else
                out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // compare every accepted result beat with the oldest one owed
    always @(posedge clk) begin : check_beats
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            n_beats++;
            if (pending_beats.size() == 0)
                flag_error($sformatf(
                    "beat %0d not owed: found %0b cell (%0d,%0d) step %0d last %0b",
                    n_beats, out_data.found, out_data.path_row,
                    out_data.path_col, out_data.step_index, out_data.last));
            else begin
                want = pending_beats.pop_front();
                if (out_data.found !== want.found)
                    flag_error($sformatf("beat %0d found %0b, want %0b",
                                         n_beats, out_data.found, want.found));
                if (out_data.path_row !== want.path_row)
                    flag_error($sformatf("beat %0d path_row %0d, want %0d",
                                         n_beats, out_data.path_row, want.path_row));
                if (out_data.path_col !== want.path_col)
                    flag_error($sformatf("beat %0d path_col %0d, want %0d",
                                         n_beats, out_data.path_col, want.path_col));
                if (out_data.step_index !== want.step_index)
                    flag_error($sformatf("beat %0d step_index %0d, want %0d",
                                         n_beats, out_data.step_index, want.step_index));
                if (out_data.last !== want.last)
                    flag_error($sformatf("beat %0d last %0b, want %0b",
                                         n_beats, out_data.last, want.last));
                if (want.last && want.found) begin
                    n_found++;
                    if (int'(want.step_index) > longest)
                        longest = int'(want.step_index);
                end else if (want.last)
                    n_missing++;
            end
        end
    end

    // hard stop if the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d result beats still owed", pending_beats.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int p;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_NUM_ROWS;
        cfg_data  = '0;
        blocked   = '{default: 1'b0};
        reg_copy  = '{NUM_ROWS_RST, NUM_COLS_RST, START_ROW_RST,
                      START_COL_RST, GOAL_ROW_RST, GOAL_COL_RST};
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        // directed table, register writes only once the block has gone quiet
        foreach (dir_plan[i]) begin
            if (dir_plan[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_plan[i].sel, dir_plan[i].value);
            end else
                issue_cmd(dir_plan[i].cmd, dir_plan[i].typed, dir_plan[i].want);
        end

        // random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            settle();
            set_phase(p);
            // long receiver hold-off while commands keep coming, so a search backs up
            if (p == 0)
                hold_req = 1'b1;
            // one phase with no idling on either side
            in_idle_pct  = (p == 3) ? 0 : IDLE_PCT;
            out_idle_pct = (p == 3) ? 0 : IDLE_PCT;
            random_phase();
        end

        settle();
        $display("%0d commands, %0d register writes, %0d searches: %0d paths, %0d none",
                 n_useful, n_writes, n_search, n_found, n_missing);
        $display("%0d result beats checked, longest path %0d cells, %0d mismatches",
                 n_beats, longest, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gmdfs_pkg.sv
rtl/gmdfs_ram.sv
rtl/grid_maze_dfs_path_search.sv
sim/tb_grid_maze_dfs_path_search.sv
